FILE: hw/rtl/pair_sum_search_macros.svh
// Assertion macros shared by the pair search design.
`ifndef PAIR_SUM_SEARCH_MACROS_SVH
`define PAIR_SUM_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/pss_pkg.sv
package pss_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // Status returned by the search unit to the control logic.
  typedef struct packed {
    logic done;
    logic found;
  } pss_status_t;

endpackage

FILE: hw/rtl/pss_search.sv
module pss_search #(
  parameter int MAX_ENTRIES = pss_pkg::MAX_ENTRIES_DEF,
  parameter int VALUE_WIDTH = pss_pkg::VALUE_WIDTH_DEF,
  parameter int IW          = $clog2(MAX_ENTRIES),
  parameter int CW          = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [IW-1:0]            wr_addr,
  input  logic [VALUE_WIDTH-1:0]   wr_data,
  input  logic                     start,
  input  logic [VALUE_WIDTH-1:0]   target_in,
  input  logic [CW-1:0]            count,
  output pss_pkg::pss_status_t     status
);
  import pss_pkg::*;

  localparam logic [1:0] W_IDLE  = 2'd0;
  localparam logic [1:0] W_HOLDA = 2'd1;
  localparam logic [1:0] W_RUN   = 2'd2;

  logic [VALUE_WIDTH-1:0] mem [MAX_ENTRIES];
  logic [VALUE_WIDTH-1:0] rd_data;
  logic [IW-1:0]          rd_addr;

  logic [1:0]             state;
  logic [1:0]             state_next;
  logic [IW-1:0]          a_idx;
  logic [IW-1:0]          b_idx;
  logic [VALUE_WIDTH-1:0] a_val;
  logic [VALUE_WIDTH-1:0] target;

  logic [VALUE_WIDTH:0]   sum;
  logic                   hit;
  logic                   b_last;
  logic                   a_last;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // The sum is one bit wider than an entry so it can never wrap.
  assign sum    = {a_val[VALUE_WIDTH-1], a_val} + {rd_data[VALUE_WIDTH-1], rd_data};
  assign hit    = (sum == {target[VALUE_WIDTH-1], target});
  assign b_last = ((CW'(b_idx) + CW'(1)) == count);
  assign a_last = ((CW'(a_idx) + CW'(2)) == count);

  always_comb begin
    state_next = state;
    rd_addr    = '0;
    status     = '0;
    unique case (state)
      W_IDLE: begin
        if (start) begin
          state_next = W_HOLDA;
        end
      end
      W_HOLDA: begin
        rd_addr    = a_idx + IW'(1);
        state_next = W_RUN;
      end
      W_RUN: begin
        if (hit) begin
          status.done  = 1'b1;
          status.found = 1'b1;
          state_next   = W_IDLE;
        end else if (b_last) begin
          if (a_last) begin
            status.done = 1'b1;
            state_next  = W_IDLE;
          end else begin
            rd_addr    = a_idx + IW'(1);
            state_next = W_HOLDA;
          end
        end else begin
          rd_addr = b_idx + IW'(1);
        end
      end
      default: begin
        state_next = W_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      W_IDLE: begin
        if (start) begin
          a_idx  <= '0;
          target <= target_in;
        end
      end
      W_HOLDA: begin
        a_val <= rd_data;
        b_idx <= a_idx + IW'(1);
      end
      W_RUN: begin
        if (!hit) begin
          if (b_last) begin
            a_idx <= a_idx + IW'(1);
          end else begin
            b_idx <= b_idx + IW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/pair_sum_search.sv
// Channel  Handshake            Word
// -------  -------------------  --------------------------------
// input    in_valid / in_ready  kind, value
// output   out_valid/out_ready  found, too_few, overflow
//
// in_ready stays high for append and clear words.
// A query checks one pair per cycle through a single adder and comparator
// fed by one memory read port, plus a fetch of each new first entry.
// A query with fewer than two entries skips the search and goes straight
// to the output register.
// Reset clears the count and the dropped flag; the value memory needs no clearing.
// A result held by out_ready low stalls the block only once the next query has its result.
module pair_sum_search #(
  parameter int MAX_ENTRIES = pss_pkg::MAX_ENTRIES_DEF,
  parameter int VALUE_WIDTH = pss_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pss_pkg::KIND_W-1:0]     kind,
  input  logic signed [VALUE_WIDTH-1:0]  value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           found,
  output logic                           too_few,
  output logic                           overflow
);
  import pss_pkg::*;

  `include "pair_sum_search_macros.svh"

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic          dropped;
  logic          pend_found;
  logic          pend_few;

  logic          accept;
  logic          is_append;
  logic          is_query;
  logic          is_clear;
  logic          has_room;
  logic          few_now;
  logic          wr_en;
  logic          start;
  pss_status_t   status;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_append = (kind == KIND_APPEND);
  assign is_query  = (kind == KIND_QUERY);
  assign is_clear  = (kind == KIND_CLEAR);
  assign has_room  = (count < CW'(MAX_ENTRIES));
  assign few_now   = (count < CW'(2));
  assign wr_en     = accept && is_append && has_room;
  assign start     = accept && is_query && !few_now;

  pss_search #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .VALUE_WIDTH (VALUE_WIDTH),
    .IW          (IW),
    .CW          (CW)
  ) u_search (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (count[IW-1:0]),
    .wr_data   (value),
    .start     (start),
    .target_in (value),
    .count     (count),
    .status    (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (is_append) begin
              if (has_room) begin
                count <= count + CW'(1);
              end else begin
                dropped <= 1'b1;
              end
            end else if (is_clear) begin
              count   <= '0;
              dropped <= 1'b0;
            end else if (is_query) begin
              state <= few_now ? ST_EMIT : ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (status.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // The output register may still hold the previous word.
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && is_query) begin
      pend_found <= 1'b0;
      pend_few   <= few_now;
    end else if (state == ST_SEARCH && status.done) begin
      pend_found <= status.found;
    end
    if (state == ST_EMIT && (!out_valid || out_ready)) begin
      found    <= pend_found;
      too_few  <= pend_few;
      overflow <= dropped;
    end
  end

  `PSS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(MAX_ENTRIES),
                  "entry count above capacity")
  `PSS_ASSERT_NOW(a_done_in_search, clk, rst, status.done, state == ST_SEARCH,
                  "search finished outside a query")
  `PSS_ASSERT_NOW(a_few_not_found, clk, rst, out_valid, !(found && too_few),
                  "pair found with too few entries")
  `PSS_ASSERT_NEXT(a_query_busy, clk, rst, accept && is_query, !in_ready,
                   "input taken during a query")

endmodule

FILE: tb/tb_pair_sum_search.sv
module tb_pair_sum_search;
  timeunit 1ns;
  timeprecision 1ps;

  import pss_pkg::*;

  localparam int MAX_N = MAX_ENTRIES_DEF;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int PHASE_WORDS = 90;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 2200;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic found;
    logic too_few;
    logic overflow;
  } search_result_t;

  class pair_sum_scoreboard;
    logic signed [31:0] entries [MAX_N];
    int unsigned n_entries = 0;
    bit dropped = 1'b0;
    search_result_t awaited [$];
    int unsigned errors = 0;
    int unsigned n_checked = 0;
    int unsigned n_hits = 0;
    int unsigned n_few = 0;
    int unsigned n_over = 0;

    // The sum is formed at 64 bits, so two extreme entries never wrap.
    function bit sum_present(logic signed [31:0] target);
      longint s;
      for (int a = 0; a < n_entries; a++) begin
        for (int b = a + 1; b < n_entries; b++) begin
          s = longint'(entries[a]) + longint'(entries[b]);
          if (s == longint'(target)) return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_word(logic [KIND_W-1:0] k, logic signed [31:0] v);
      search_result_t r;
      case (k)
        KIND_APPEND: begin
          if (n_entries < MAX_N) begin
            entries[n_entries] = v;
            n_entries++;
          end else begin
            dropped = 1'b1;
          end
        end
        KIND_CLEAR: begin
          n_entries = 0;
          dropped = 1'b0;
        end
        KIND_QUERY: begin
          r.too_few = (n_entries < 2);
          r.found = !r.too_few && sum_present(v);
          r.overflow = dropped;
          awaited.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(search_result_t got);
      search_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing expected: found %0b too_few %0b overflow %0b",
                 $time, got.found, got.too_few, got.overflow);
        errors++;
        return;
      end
      want = awaited.pop_front();
      n_checked++;
      if (want.found) n_hits++;
      if (want.too_few) n_few++;
      if (want.overflow) n_over++;
      if (got.found !== want.found) begin
        $display("%0t: found mismatch: expected %0b actual %0b", $time, want.found, got.found);
        errors++;
      end
      if (got.too_few !== want.too_few) begin
        $display("%0t: too_few mismatch: expected %0b actual %0b",
                 $time, want.too_few, got.too_few);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow mismatch: expected %0b actual %0b",
                 $time, want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid;
  logic in_ready;
  logic [KIND_W-1:0] kind;
  logic signed [31:0] value;
  logic out_valid;
  logic out_ready;
  logic found;
  logic too_few;
  logic overflow;

  pair_sum_scoreboard scb = new;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_requests = 0;
  int n_words = 0;
  int cycles = 0;

  pair_sum_search uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .found(found),
    .too_few(too_few),
    .overflow(overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = 32'sd0;
          default: v = -32'sd1;
        endcase
      end
      1, 2, 3: v = int'($urandom_range(40)) - 20;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // With two or more entries stored, half the targets are the sum of two of them, so hits are common.
  function automatic logic signed [31:0] pick_target();
    int a;
    int b;
    int roll;
    logic signed [31:0] t;
    roll = $urandom_range(99);
    if (scb.n_entries >= 2 && roll < 50) begin
      a = $urandom_range(scb.n_entries - 1);
      b = $urandom_range(scb.n_entries - 2);
      if (b >= a) b++;
      t = scb.entries[a] + scb.entries[b];
    end else if (scb.n_entries >= 1 && roll < 65) begin
      a = $urandom_range(scb.n_entries - 1);
      t = scb.entries[a] <<< 1;
    end else begin
      t = pick_value();
    end
    return t;
  endfunction

  task automatic send_word(input logic [KIND_W-1:0] k, input logic signed [31:0] v);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scb.note_word(k, v);
    if (k != KIND_UNUSED) n_words++;
  endtask

  // Always waits on the clock before checking, so valid is never lowered and raised in one step.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (scb.awaited.size() != 0);
  endtask

  task automatic run_sequence();
    int n_app;
    int n_qry;
    n_app = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 8);
    n_qry = $urandom_range(1, 4);
    if (scb.n_entries > 10 || $urandom_range(9) < 6) send_word(KIND_CLEAR, pick_value());
    repeat (n_app) send_word(KIND_APPEND, pick_value());
    if ($urandom_range(19) == 0) send_word(KIND_UNUSED, pick_value());
    repeat (n_qry) begin
      if ($urandom_range(3) == 0) send_word(KIND_APPEND, pick_value());
      send_word(KIND_QUERY, pick_target());
    end
  endtask

  task automatic fill_list();
    send_word(KIND_CLEAR, pick_value());
    repeat (MAX_N) send_word(KIND_APPEND, pick_value());
    send_word(KIND_QUERY, pick_target());
    repeat ($urandom_range(2, 4)) send_word(KIND_APPEND, pick_value());
    send_word(KIND_QUERY, pick_target());
    send_word(KIND_QUERY, pick_value());
    send_word(KIND_CLEAR, pick_value());
    send_word(KIND_QUERY, pick_value());
  endtask

  // Receiver: checks each accepted result and drives out_ready, with an
  // occasional long hold-off that lets the block back up into its input.
  initial begin
    int hold_left;
    int holds_taken;
    search_result_t got;
    hold_left = 0;
    holds_taken = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.found = found;
        got.too_few = too_few;
        got.overflow = overflow;
        scb.check_result(got);
      end
      if (holds_taken != hold_requests) begin
        holds_taken = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int phase_start;
    in_valid <= 1'b0;
    kind <= KIND_APPEND;
    value <= 32'sd0;
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle = 37;
    recv_idle <= 52;

    // Directed words: empty and single-entry lists, extreme sums that would
    // wrap at 32 bits, an entry paired with itself, an unused kind and a clear.
    send_word(KIND_QUERY, 32'sd0);
    send_word(KIND_APPEND, VAL_MIN);
    send_word(KIND_QUERY, VAL_MIN);
    send_word(KIND_APPEND, VAL_MIN);
    send_word(KIND_QUERY, 32'sd0);
    send_word(KIND_APPEND, VAL_MAX);
    send_word(KIND_APPEND, VAL_MAX);
    send_word(KIND_QUERY, -32'sd1);
    send_word(KIND_QUERY, -32'sd2);
    send_word(KIND_APPEND, 32'sd5);
    send_word(KIND_QUERY, 32'sd10);
    send_word(KIND_UNUSED, -32'sd1);
    send_word(KIND_QUERY, 32'sd10);
    send_word(KIND_QUERY, VAL_MIN + 32'sd5);
    send_word(KIND_CLEAR, VAL_MAX);
    send_word(KIND_QUERY, 32'sd0);
    send_word(KIND_APPEND, 32'sd0);
    send_word(KIND_APPEND, 32'sd0);
    send_word(KIND_QUERY, 32'sd0);
    send_word(KIND_APPEND, 32'sd1);
    send_word(KIND_QUERY, 32'sd1);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 37 : (ph == 1) ? 52 : 0;
      recv_idle <= (ph == 0) ? 52 : (ph == 1) ? 37 : 0;
      phase_start = n_words;
      if (ph == 1) begin
        hold_requests <= hold_requests + 1;
        send_word(KIND_CLEAR, pick_value());
        repeat (4) send_word(KIND_APPEND, pick_value());
        send_word(KIND_QUERY, pick_target());
        repeat (5) send_word(KIND_APPEND, pick_value());
        send_word(KIND_QUERY, pick_target());
        send_word(KIND_QUERY, pick_target());
      end
      if (ph == 2) fill_list();
      while (n_words - phase_start < PHASE_WORDS) run_sequence();
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d words in %0d cycles; checked %0d query results.",
             n_words, cycles, scb.n_checked);
    $display("Results: %0d pairs found, %0d with too few entries, %0d after a dropped append.",
             scb.n_hits, scb.n_few, scb.n_over);
    if (scb.errors == 0 && scb.awaited.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/pss_pkg.sv
hw/rtl/pss_search.sv
hw/rtl/pair_sum_search.sv
tb/tb_pair_sum_search.sv
